@@ sv/tsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types, constants and helpers of the tire slip angle block.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int CORDIC_STEPS_DEF = 18;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int ANG_BITS         = 30;

    // Payload widths
    localparam int SPEED_W   = 24;
    localparam int STEER_W   = 19;
    localparam int SLIP_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 23;
    localparam int WB_W      = 23;
    localparam int FF_W      = 17;
    localparam int TW_W      = 23;

    // Internal widths
    localparam int WIDE_W  = 32;   // saturated intermediates
    localparam int VEC_W   = 35;   // CORDIC x and y, leaves headroom for gain
    localparam int LEVER_W = 31;   // lever arm, unsigned, saturated

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_FRACTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_WIDTH    = 2'd2;

    // Configuration reset values
    localparam logic [WB_W-1:0] WHEELBASE_RST      = 23'd100270;
    localparam logic [FF_W-1:0] FRONT_FRACTION_RST = 17'd32768;
    localparam logic [TW_W-1:0] TRACK_WIDTH_RST    = 23'd78643;

    // Sign of the numerator, kept for the zero divisor case
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam logic signed [SLIP_W-1:0] SLIP_HI = 20'sd524287;
    localparam logic signed [SLIP_W-1:0] SLIP_LO = -20'sd524288;

    typedef struct packed {
        logic signed [VEC_W-1:0]   x;
        logic signed [VEC_W-1:0]   y;
        logic signed [WIDE_W-1:0]  z;
        logic                      zero;
        logic [1:0]                nsign;
        logic                      front;
        logic signed [STEER_W-1:0] steer;
    } t_cordic;

    // Arctangent of 2^-i in Q2.30
    function automatic logic signed [WIDE_W-1:0] atan_q30(input int i);
        logic signed [WIDE_W-1:0] v;
        case (i)
            0:       v = 32'sh3243F6A9;
            1:       v = 32'sh1DAC6705;
            2:       v = 32'sh0FADBAFD;
            3:       v = 32'sh07F56EA7;
            4:       v = 32'sh03FEAB77;
            5:       v = 32'sh01FFD55C;
            6:       v = 32'sh00FFFAAB;
            7:       v = 32'sh007FFF55;
            8:       v = 32'sh003FFFEB;
            9:       v = 32'sh001FFFFD;
            10:      v = 32'sh00100000;
            11:      v = 32'sh00080000;
            12:      v = 32'sh00040000;
            13:      v = 32'sh00020000;
            14:      v = 32'sh00010000;
            15:      v = 32'sh00008000;
            16:      v = 32'sh00004000;
            17:      v = 32'sh00002000;
            18:      v = 32'sh00001000;
            19:      v = 32'sh00000800;
            20:      v = 32'sh00000400;
            21:      v = 32'sh00000200;
            22:      v = 32'sh00000100;
            23:      v = 32'sh00000080;
            default: v = 32'sh00000000;
        endcase
        return v;
    endfunction

    // Saturate to the signed 32 bit range
    function automatic logic signed [WIDE_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [WIDE_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[WIDE_W-1:0];
        end
        return r;
    endfunction

    // Clamp an already shifted lever product to the positive 32 bit range
    function automatic logic [LEVER_W-1:0] lever_sat(input logic [39:0] v);
        logic [LEVER_W-1:0] r;
        if (v > 40'h007FFFFFFF) begin
            r = {LEVER_W{1'b1}};
        end else begin
            r = v[LEVER_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/tsa_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface tsa_cfg_if import tsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/tsa_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_in_if
// Vehicle state channel: one axle sample per transaction.
// ----------------------------------------------------------------------------
interface tsa_in_if import tsa_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_forward;
    logic signed [SPEED_W-1:0] speed_lateral;
    logic signed [SPEED_W-1:0] yaw_rate;
    logic signed [STEER_W-1:0] steer_angle;
    logic                      front_axle;

    modport source (output valid, output speed_forward, output speed_lateral,
                    output yaw_rate, output steer_angle, output front_axle,
                    input ready);
    modport sink   (input valid, input speed_forward, input speed_lateral,
                    input yaw_rate, input steer_angle, input front_axle,
                    output ready);
endinterface

@@ sv/tsa_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_out_if
// Result channel: slip angle and zero divisor flag.
// ----------------------------------------------------------------------------
interface tsa_out_if import tsa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [SLIP_W-1:0] slip_angle;
    logic                     zero_divisor;

    modport source (output valid, output slip_angle, output zero_divisor, input ready);
    modport sink   (input valid, input slip_angle, input zero_divisor, output ready);
endinterface

@@ sv/tire_slip_angle.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tire_slip_angle
// Throughput: one transaction per cycle; four front stages, one CORDIC cell per
// step and two back stages, each advancing whenever its successor moves or is empty.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// configuration registers with their defaults. Input ready is low during reset.
// ----------------------------------------------------------------------------
module tire_slip_angle import tsa_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsa_cfg_if.sink    i_cfg,
    tsa_in_if.sink     i_in,
    tsa_out_if.source  o_out
);

    logic    chain_valid [0:CORDIC_STEPS];
    t_cordic chain_data  [0:CORDIC_STEPS];
    logic    chain_adv   [0:CORDIC_STEPS];

    tsa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_in    (i_in),
        .i_adv   (chain_adv[0]),
        .o_valid (chain_valid[0]),
        .o_data  (chain_data[0])
    );

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        tsa_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .i_data  (chain_data[k]),
            .o_take  (chain_adv[k]),
            .i_adv   (chain_adv[k+1]),
            .o_valid (chain_valid[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    tsa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[CORDIC_STEPS]),
        .i_data  (chain_data[CORDIC_STEPS]),
        .o_take  (chain_adv[CORDIC_STEPS]),
        .o_out   (o_out)
    );

endmodule

@@ sv/tsa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_front
// Configuration registers and the four stages that form numerator and
// denominator and fold them into the right half plane for the CORDIC row.
// ----------------------------------------------------------------------------
module tsa_front import tsa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsa_cfg_if.sink     i_cfg,
    tsa_in_if.sink      i_in,
    input  logic        i_adv,
    output logic        o_valid,
    output t_cordic     o_data
);

    localparam logic [39:0] RST_LEV_PROD =
        40'(WHEELBASE_RST) * 40'(FRONT_FRACTION_RST);
    localparam logic [LEVER_W-1:0] RST_LEVER = lever_sat(RST_LEV_PROD >> FRAC_BITS);
    localparam logic signed [WIDE_W-1:0] VX_MIN = 32'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic signed [WIDE_W-1:0]  vx;
        logic signed [SPEED_W-1:0] vy;
        logic signed [SPEED_W-1:0] yaw;
        logic signed [STEER_W-1:0] steer;
        logic                      front;
    } t_stage_a;

    typedef struct packed {
        logic signed [WIDE_W-1:0]  vx;
        logic signed [WIDE_W-1:0]  vy;
        logic signed [WIDE_W-1:0]  ly;
        logic signed [WIDE_W-1:0]  hy;
        logic signed [STEER_W-1:0] steer;
        logic                      front;
    } t_stage_b;

    typedef struct packed {
        logic signed [WIDE_W-1:0]  den;
        logic signed [WIDE_W-1:0]  num;
        logic signed [STEER_W-1:0] steer;
        logic                      front;
    } t_stage_c;

    logic [WB_W-1:0]    r_wheelbase;
    logic [FF_W-1:0]    r_front_fraction;
    logic [TW_W-1:0]    r_track_width;
    logic [LEVER_W-1:0] r_lever;
    logic [39:0]        lev_prod;

    logic     r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    t_stage_a r_a, n_a;
    t_stage_b r_b, n_b;
    t_stage_c r_c, n_c;
    t_cordic  r_d, n_d;
    logic     take_a, take_b, take_c, take_d;

    logic signed [55:0] ly_prod;
    logic signed [47:0] hy_prod;
    logic signed [WIDE_W-1:0] vx_ext;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheelbase      <= WHEELBASE_RST;
            r_front_fraction <= FRONT_FRACTION_RST;
            r_track_width    <= TRACK_WIDTH_RST;
            r_lever          <= RST_LEVER;
        end else begin
            r_lever <= lever_sat(lev_prod >> FRAC_BITS);
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_WHEELBASE:      r_wheelbase      <= i_cfg.data[WB_W-1:0];
                    REG_FRONT_FRACTION: r_front_fraction <= i_cfg.data[FF_W-1:0];
                    REG_TRACK_WIDTH:    r_track_width    <= i_cfg.data[TW_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign lev_prod = 40'(r_wheelbase) * 40'(r_front_fraction);

    // Enable chain: a stage loads when it is empty or its consumer moves
    assign take_d = !r_d_valid || i_adv;
    assign take_c = !r_c_valid || take_d;
    assign take_b = !r_b_valid || take_c;
    assign take_a = !r_a_valid || take_b;

    assign i_in.ready = take_a && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (take_a) r_a_valid <= i_in.valid;
            if (take_b) r_b_valid <= r_a_valid;
            if (take_c) r_c_valid <= r_b_valid;
            if (take_d) r_d_valid <= r_c_valid;
        end
    end

    // Stage A: capture and clamp forward speed to at least one
    assign vx_ext = WIDE_W'(i_in.speed_forward);

    always_comb begin
        n_a.vx    = (vx_ext < VX_MIN) ? VX_MIN : vx_ext;
        n_a.vy    = i_in.speed_lateral;
        n_a.yaw   = i_in.yaw_rate;
        n_a.steer = i_in.steer_angle;
        n_a.front = i_in.front_axle;
    end

    // Stage B: yaw products
    assign ly_prod = 56'($signed({1'b0, r_lever})) * 56'(r_a.yaw);
    assign hy_prod = 48'($signed({1'b0, r_track_width})) * 48'(r_a.yaw);

    always_comb begin
        n_b.vx    = r_a.vx;
        n_b.vy    = WIDE_W'(r_a.vy);
        n_b.ly    = sat32(64'(ly_prod >>> FRAC_BITS));
        n_b.hy    = sat32(64'(hy_prod >>> (FRAC_BITS + 1)));
        n_b.steer = r_a.steer;
        n_b.front = r_a.front;
    end

    // Stage C: numerator and denominator
    always_comb begin
        n_c.den   = sat32(64'(r_b.vx) - 64'(r_b.hy));
        n_c.num   = r_b.front ? sat32(64'(r_b.vy) + 64'(r_b.ly))
                              : sat32(64'(r_b.vy) - 64'(r_b.ly));
        n_c.steer = r_b.steer;
        n_c.front = r_b.front;
    end

    // Stage D: flag zero divisor, negate both when the divisor is negative
    always_comb begin
        n_d.zero  = (r_c.den == '0);
        n_d.x     = r_c.den[WIDE_W-1] ? -VEC_W'(r_c.den) : VEC_W'(r_c.den);
        n_d.y     = r_c.den[WIDE_W-1] ? -VEC_W'(r_c.num) : VEC_W'(r_c.num);
        n_d.z     = '0;
        if (r_c.num == '0) begin
            n_d.nsign = SIGN_ZERO;
        end else if (r_c.num[WIDE_W-1]) begin
            n_d.nsign = SIGN_NEG;
        end else begin
            n_d.nsign = SIGN_POS;
        end
        n_d.steer = r_c.steer;
        n_d.front = r_c.front;
    end

    always_ff @(posedge i_clk) begin
        if (take_a) r_a <= n_a;
        if (take_b) r_b <= n_b;
        if (take_c) r_c <= n_c;
        if (take_d) r_d <= n_d;
    end

    assign o_valid = r_d_valid;
    assign o_data  = r_d;

endmodule

@@ sv/tsa_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_cell
// One vectoring CORDIC micro-rotation with its own stage register.
// ----------------------------------------------------------------------------
module tsa_cell import tsa_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_cordic i_data,
    output logic    o_take,
    input  logic    i_adv,
    output logic    o_valid,
    output t_cordic o_data
);

    localparam logic signed [WIDE_W-1:0] ATAN_STEP = atan_q30(STEP);

    logic    r_valid;
    t_cordic r_data, n_data;
    logic signed [VEC_W-1:0] dx, dy;

    assign o_take = !r_valid || i_adv;

    assign dx = i_data.y >>> STEP;
    assign dy = i_data.x >>> STEP;

    // Rotate toward the x axis; y drives the direction
    always_comb begin
        n_data = i_data;
        if (i_data.y > 0) begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ATAN_STEP;
        end else begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ sv/tsa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_back
// Angle rounding, zero divisor substitution, steering correction and the
// output register.
// ----------------------------------------------------------------------------
module tsa_back import tsa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cordic     i_data,
    output logic        o_take,
    tsa_out_if.source   o_out
);

    localparam int SH = ANG_BITS - FRAC_BITS;
    localparam logic signed [32:0] ROUND_HALF = 33'sd1 <<< (SH - 1);
    localparam logic signed [32:0] HALF_ANG =
        33'((HALF_PI_Q30 + (64'sd1 <<< (SH - 1))) >>> SH);

    logic                      r_e_valid, r_f_valid;
    logic signed [32:0]        r_e_ang, n_e_ang;
    logic signed [STEER_W-1:0] r_e_steer;
    logic                      r_e_front, r_e_zero;
    logic signed [SLIP_W-1:0]  r_f_slip, n_f_slip;
    logic                      r_f_zero;
    logic                      take_e, take_f;
    logic signed [32:0]        z_rnd;
    logic signed [33:0]        res;

    assign take_f = !r_f_valid || o_out.ready;
    assign take_e = !r_e_valid || take_f;
    assign o_take = take_e;

    // Stage E: round Q2.30 angle; on a zero divisor substitute plus or minus pi/2, or zero for a zero numerator
    assign z_rnd = 33'(i_data.z) + ROUND_HALF;

    always_comb begin
        if (i_data.zero) begin
            case (i_data.nsign)
                SIGN_POS: n_e_ang = HALF_ANG;
                SIGN_NEG: n_e_ang = -HALF_ANG;
                default:  n_e_ang = '0;
            endcase
        end else begin
            n_e_ang = z_rnd >>> SH;
        end
    end

    // Stage F: steering correction for the front axle, saturate
    assign res = r_e_front ? 34'(r_e_ang) - 34'(r_e_steer) : 34'(r_e_ang);

    always_comb begin
        if (res > 34'(SLIP_HI)) begin
            n_f_slip = SLIP_HI;
        end else if (res < 34'(SLIP_LO)) begin
            n_f_slip = SLIP_LO;
        end else begin
            n_f_slip = res[SLIP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            if (take_e) r_e_valid <= i_valid;
            if (take_f) r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_e) begin
            r_e_ang   <= n_e_ang;
            r_e_steer <= i_data.steer;
            r_e_front <= i_data.front;
            r_e_zero  <= i_data.zero;
        end
        if (take_f) begin
            r_f_slip <= n_f_slip;
            r_f_zero <= r_e_zero;
        end
    end

    assign o_out.valid        = r_f_valid;
    assign o_out.slip_angle   = r_f_slip;
    assign o_out.zero_divisor = r_f_zero;

endmodule
